// ===== sv/bucket_priority_queue_evicting_core_assert.svh =====
// assertion macros used by the checker file
`ifndef BUCKET_PRIORITY_QUEUE_EVICTING_CORE_ASSERT_SVH
`define BUCKET_PRIORITY_QUEUE_EVICTING_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define BPQE_ASSERT_NOW(lbl, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define BPQE_ASSERT_NEXT(lbl, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error(msg);

`endif

// ===== sv/bpqe_pkg.sv =====
// ----------------------------------------------------------------------------
// bpqe_pkg
// shared constants, codes and the bit search used by the bucket queue
// ----------------------------------------------------------------------------
package bpqe_pkg;

	localparam int SLOT_COUNT = 1024;
	localparam int SLOT_W     = 10;
	localparam int PTR_W      = 11;
	localparam logic [PTR_W-1:0] NIL = 11'd1024;
	localparam int BUCKETS    = 256;
	localparam logic [7:0] TOP_LEVEL = 8'd255;
	localparam int WORDS      = 4;
	localparam int WORD_BITS  = 64;
	localparam int ID_W       = 31;
	localparam int COUNT_W    = 11;

	// operation codes
	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_POP  = 1'b1;

	// status codes
	localparam logic [2:0] ST_PUSHED  = 3'd0;
	localparam logic [2:0] ST_EVICTED = 3'd1;
	localparam logic [2:0] ST_DROPPED = 3'd2;
	localparam logic [2:0] ST_POPPED  = 3'd3;
	localparam logic [2:0] ST_EMPTY   = 3'd4;

	// index of the highest (from_top) or lowest set bit of a word
	function automatic logic [5:0] find_bit(input logic [WORD_BITS-1:0] word,
		input logic from_top);
		logic [5:0] idx;
		idx = 6'd0;
		if (from_top) begin
			for (int k = 0; k < WORD_BITS; k++) begin
				if (word[k]) idx = 6'(k);
			end
		end else begin
			for (int k = WORD_BITS - 1; k >= 0; k--) begin
				if (word[k]) idx = 6'(k);
			end
		end
		return idx;
	endfunction

endpackage

// ===== sv/bpqe_ram.sv =====
// ----------------------------------------------------------------------------
// bpqe_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module bpqe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/bucket_priority_queue_evicting_core.sv =====
// ----------------------------------------------------------------------------
// bucket_priority_queue_evicting_core
// bucketed priority queue of 1024 slots with eviction of the lowest bucket
// ----------------------------------------------------------------------------
// One item at a time: s_tready is high only while idle, and the result is held
// on the master side until taken. A push into a store that is not full passes
// through allocation, the slot write and, into a non-empty bucket, a tail link
// write; a pop runs the bitmap scan, one 64-bit word a cycle, then the
// dependent head and link reads (S_EVRH, S_EVRL, S_EVWH); a push into a full
// store adds the scan and the eviction states before the allocation. The steps
// follow from the chain of registered reads of the head, tail and link memories
// and the word-serial occupancy scan. No clearing pass is needed after reset:
// never-used slots are handed out from a fresh-slot counter.
module bucket_priority_queue_evicting_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // item_id[30:0], bucket[38:31], zero pad
	input  logic        s_tuser,  // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // popped_id[30:0], entry_count[41:31], zero pad
	output logic [2:0]  m_tuser   // status
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SCAN  = 4'd1;
	localparam logic [3:0] S_EVRH  = 4'd2;
	localparam logic [3:0] S_EVRL  = 4'd3;
	localparam logic [3:0] S_EVWH  = 4'd4;
	localparam logic [3:0] S_ALLOC = 4'd5;
	localparam logic [3:0] S_ALWR  = 4'd6;
	localparam logic [3:0] S_ALLNK = 4'd7;
	localparam logic [3:0] S_OUT   = 4'd8;

	logic [3:0] state_q;
	logic       func_q;
	logic [bpqe_pkg::ID_W-1:0] id_q;
	logic [7:0] b_q;
	logic [7:0] scan_b_q;
	logic [1:0] w_q;
	logic       evict_q;
	logic [bpqe_pkg::SLOT_W-1:0] s_q;
	logic [bpqe_pkg::PTR_W-1:0]  tail_q;
	logic [bpqe_pkg::PTR_W-1:0]  free_ptr_q;
	logic [bpqe_pkg::PTR_W-1:0]  fresh_q;
	logic [bpqe_pkg::COUNT_W-1:0] count_q;
	logic [bpqe_pkg::WORDS-1:0][bpqe_pkg::WORD_BITS-1:0] bitmap_q;
	logic [2:0] status_q;
	logic [bpqe_pkg::ID_W-1:0] popped_q;

	// memory ports
	logic       head_we, tail_we, link_we, id_we;
	logic [7:0] head_waddr, head_raddr, tail_raddr;
	logic [bpqe_pkg::PTR_W-1:0] head_wdata, head_rdata, tail_rdata;
	logic [bpqe_pkg::PTR_W-1:0] link_wdata, link_rdata;
	logic [bpqe_pkg::SLOT_W-1:0] link_waddr, link_raddr, id_addr;
	logic [bpqe_pkg::ID_W-1:0]  id_rdata;

	logic [5:0] scan_idx;
	logic [7:0] scan_hit;
	logic [7:0] in_bucket;
	logic [bpqe_pkg::PTR_W-1:0] alloc_next;
	logic       is_fresh;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_OUT);
	assign m_tuser  = status_q;
	assign m_tdata  = {6'd0, count_q, popped_q};

	// saturate the requested bucket
	assign in_bucket = (s_tdata[38:31] > bpqe_pkg::TOP_LEVEL) ? bpqe_pkg::TOP_LEVEL
		: s_tdata[38:31];

	// shared word scanner: highest bit for pop, lowest for a full push
	assign scan_idx = bpqe_pkg::find_bit(bitmap_q[w_q], func_q == bpqe_pkg::FUNC_POP);
	assign scan_hit = {w_q, scan_idx};

	// next free slot: never-used slots chain to the following index
	assign is_fresh   = (free_ptr_q == fresh_q);
	assign alloc_next = is_fresh ? (free_ptr_q + bpqe_pkg::PTR_W'(1)) : link_rdata;

	// memory address and write control
	always_comb begin
		head_we    = 1'b0;
		head_waddr = scan_b_q;
		head_wdata = link_rdata;
		head_raddr = scan_b_q;
		tail_we    = 1'b0;
		tail_raddr = b_q;
		link_we    = 1'b0;
		link_waddr = s_q;
		link_wdata = free_ptr_q;
		link_raddr = head_rdata[bpqe_pkg::SLOT_W-1:0];
		id_we      = 1'b0;
		id_addr    = head_rdata[bpqe_pkg::SLOT_W-1:0];
		case (state_q)
			S_EVWH: begin
				head_we = 1'b1;
				link_we = 1'b1;
			end
			S_ALLOC: begin
				link_raddr = free_ptr_q[bpqe_pkg::SLOT_W-1:0];
			end
			S_ALWR: begin
				head_we    = !bitmap_q[b_q[7:6]][b_q[5:0]];
				head_waddr = b_q;
				head_wdata = free_ptr_q;
				tail_we    = 1'b1;
				link_we    = 1'b1;
				link_waddr = free_ptr_q[bpqe_pkg::SLOT_W-1:0];
				link_wdata = bpqe_pkg::NIL;
				id_we      = 1'b1;
				id_addr    = free_ptr_q[bpqe_pkg::SLOT_W-1:0];
			end
			S_ALLNK: begin
				link_we    = 1'b1;
				link_waddr = tail_q[bpqe_pkg::SLOT_W-1:0];
				link_wdata = {1'b0, s_q};
			end
			default: begin
			end
		endcase
	end

	bpqe_ram #(.WIDTH(bpqe_pkg::PTR_W), .DEPTH(bpqe_pkg::BUCKETS)) u_head (
		.clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
		.raddr(head_raddr), .rdata(head_rdata)
	);

	bpqe_ram #(.WIDTH(bpqe_pkg::PTR_W), .DEPTH(bpqe_pkg::BUCKETS)) u_tail (
		.clk(clk), .we(tail_we), .waddr(b_q), .wdata(free_ptr_q),
		.raddr(tail_raddr), .rdata(tail_rdata)
	);

	bpqe_ram #(.WIDTH(bpqe_pkg::PTR_W), .DEPTH(bpqe_pkg::SLOT_COUNT)) u_link (
		.clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
		.raddr(link_raddr), .rdata(link_rdata)
	);

	bpqe_ram #(.WIDTH(bpqe_pkg::ID_W), .DEPTH(bpqe_pkg::SLOT_COUNT)) u_id (
		.clk(clk), .we(id_we), .waddr(id_addr), .wdata(id_q),
		.raddr(id_addr), .rdata(id_rdata)
	);

	// payload capture
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_q <= s_tuser;
			id_q   <= s_tdata[30:0];
			b_q    <= in_bucket;
		end
		if (state_q == S_EVRL) s_q <= head_rdata[bpqe_pkg::SLOT_W-1:0];
		if (state_q == S_ALWR) begin
			tail_q <= tail_rdata;
			s_q    <= free_ptr_q[bpqe_pkg::SLOT_W-1:0];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			w_q         <= 2'd0;
			scan_b_q    <= 8'd0;
			evict_q     <= 1'b0;
			free_ptr_q  <= '0;
			fresh_q     <= '0;
			count_q     <= '0;
			bitmap_q    <= '0;
			status_q    <= bpqe_pkg::ST_PUSHED;
			popped_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						evict_q  <= 1'b0;
						popped_q <= '0;
						if (s_tuser == bpqe_pkg::FUNC_POP) begin
							w_q     <= 2'd3;
							state_q <= S_SCAN;
						end else if (count_q >= bpqe_pkg::COUNT_W'(bpqe_pkg::SLOT_COUNT)) begin
							w_q     <= 2'd0;
							state_q <= S_SCAN;
						end else begin
							state_q <= S_ALLOC;
						end
					end
				end
				S_SCAN: begin
					if (bitmap_q[w_q] != '0) begin
						scan_b_q <= scan_hit;
						if (func_q == bpqe_pkg::FUNC_POP) begin
							state_q <= S_EVRH;
						end else if (b_q > scan_hit) begin
							evict_q <= 1'b1;
							state_q <= S_EVRH;
						end else begin
							status_q <= bpqe_pkg::ST_DROPPED;
							state_q  <= S_OUT;
						end
					end else if ((func_q == bpqe_pkg::FUNC_POP && w_q == 2'd0) ||
						(func_q == bpqe_pkg::FUNC_PUSH && w_q == 2'd3)) begin
						status_q <= (func_q == bpqe_pkg::FUNC_POP) ? bpqe_pkg::ST_EMPTY
							: bpqe_pkg::ST_DROPPED;
						state_q  <= S_OUT;
					end else begin
						w_q <= (func_q == bpqe_pkg::FUNC_POP) ? w_q - 2'd1 : w_q + 2'd1;
					end
				end
				S_EVRH: state_q <= S_EVRL;
				S_EVRL: state_q <= S_EVWH;
				// unlink head, release the slot
				S_EVWH: begin
					if (link_rdata == bpqe_pkg::NIL)
						bitmap_q[scan_b_q[7:6]][scan_b_q[5:0]] <= 1'b0;
					free_ptr_q <= {1'b0, s_q};
					count_q    <= count_q - bpqe_pkg::COUNT_W'(1);
					if (func_q == bpqe_pkg::FUNC_POP) begin
						popped_q <= id_rdata;
						status_q <= bpqe_pkg::ST_POPPED;
						state_q  <= S_OUT;
					end else begin
						state_q <= S_ALLOC;
					end
				end
				S_ALLOC: begin
					if (free_ptr_q == bpqe_pkg::NIL) begin
						status_q <= bpqe_pkg::ST_DROPPED;
						state_q  <= S_OUT;
					end else begin
						state_q <= S_ALWR;
					end
				end
				// take the free slot and append it to the bucket
				S_ALWR: begin
					free_ptr_q <= alloc_next;
					if (is_fresh) fresh_q <= fresh_q + bpqe_pkg::PTR_W'(1);
					count_q  <= count_q + bpqe_pkg::COUNT_W'(1);
					status_q <= evict_q ? bpqe_pkg::ST_EVICTED : bpqe_pkg::ST_PUSHED;
					if (bitmap_q[b_q[7:6]][b_q[5:0]]) begin
						state_q <= S_ALLNK;
					end else begin
						bitmap_q[b_q[7:6]][b_q[5:0]] <= 1'b1;
						state_q <= S_OUT;
					end
				end
				S_ALLNK: state_q <= S_OUT;
				S_OUT: begin
					if (m_tready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== sv/bpqe_checker.sv =====
// ----------------------------------------------------------------------------
// bpqe_checker
// port-level checks of the bucket queue, bound to the top level
// ----------------------------------------------------------------------------
`include "bucket_priority_queue_evicting_core_assert.svh"

module bpqe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic [2:0]  m_tuser
);

	localparam logic [10:0] MAX_COUNT = bpqe_pkg::COUNT_W'(bpqe_pkg::SLOT_COUNT);

	// a result waiting to be taken holds its value
	`BPQE_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable({m_tuser, m_tdata}), "held")

	// one item at a time: never ready while a result is shown
	`BPQE_ASSERT_NOW(a_excl, m_tvalid, !s_tready, "ready while result pending")

	// an accepted item closes the input side next cycle
	`BPQE_ASSERT_NEXT(a_busy, s_tvalid && s_tready, !s_tready && !m_tvalid, "ready after accept")

	// status is a known code
	`BPQE_ASSERT_NOW(a_status, m_tvalid, m_tuser <= bpqe_pkg::ST_EMPTY, "status out of range")

	// count stays within the store
	`BPQE_ASSERT_NOW(a_count, m_tvalid, m_tdata[41:31] <= MAX_COUNT, "count out of range")

endmodule

bind bucket_priority_queue_evicting_core bpqe_checker u_bpqe_checker (
	.clk(clk), .arst_n(arst_n),
	.s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
